[design/orht_pkg.sv]
`timescale 1ns / 1ps
package orht_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_ADDR_BITS   = 48;
  localparam int DEF_NUM_PORTS   = 8;
  localparam logic [4:0] MAX_OUT_RESET = 5'd16;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_COMMIT = 2'd1;
  localparam logic [1:0] OP_COMPL  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] EV_ACCEPT  = 3'd0;
  localparam logic [2:0] EV_REFUSE  = 3'd1;
  localparam logic [2:0] EV_PERFORM = 3'd2;
  localparam logic [2:0] EV_RESPOND = 3'd3;
  localparam logic [2:0] EV_HELD    = 3'd4;
  localparam logic [2:0] EV_PARKED  = 3'd5;

  localparam logic [2:0] FLT_NONE       = 3'd0;
  localparam logic [2:0] FLT_TAG_USED   = 3'd1;
  localparam logic [2:0] FLT_UNKNOWN    = 3'd2;
  localparam logic [2:0] FLT_TWICE      = 3'd3;
  localparam logic [2:0] FLT_ADDR       = 3'd4;
  localparam logic [2:0] FLT_EARLY_CMPL = 3'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  tag;
    logic [47:0] address;
    logic [6:0]  length;
    logic        write_req;
    logic [2:0]  port;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] fault;
    logic [3:0] out_tag;
    logic [2:0] out_port;
    logic       out_write;
    logic       last;
  } out_item_t;

endpackage

[design/outstanding_request_hazard_table.sv]
`timescale 1ns / 1ps
// Outstanding request hazard table.
// Input channel in_valid/in_stall/in_data carries submit, commit and completion
// transactions; each one produces a burst of result transactions on
// out_valid/out_stall/out_data, the final one flagged by last (opcode 3 gives
// none). cfg_valid/cfg_ready/cfg_data writes max_outstanding; cfg_ready is
// always high.
// One item is worked at a time; in_stall is high while it is in progress.
// A commit runs a hazard scan over every table entry through one shared
// overlap comparator; each release pass adds a scan to find the oldest
// held entry plus a scan to check it, so a cascading release repeats both
// scans for every retried entry.
// Results are staged one deep so the last flag is known; while the receiver
// stalls, the sequencer waits on each new result.
// Synchronous reset empties the table, clears the age counter and pending
// count, and sets max_outstanding to 16. Table contents need no clearing.
module outstanding_request_hazard_table #(
  parameter int TABLE_DEPTH = orht_pkg::DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = orht_pkg::DEF_ADDR_BITS,
  parameter int NUM_PORTS   = orht_pkg::DEF_NUM_PORTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  orht_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output orht_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);
  import orht_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_ACT    = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;
  localparam logic [2:0] S_FIND   = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;

  logic [2:0] state;
  in_item_t   item;
  logic [4:0] max_outstanding;
  logic [CW-1:0] pending_count;
  logic [63:0] next_age;

  logic [TABLE_DEPTH-1:0] slot_valid, slot_committed, slot_data_done, slot_completion_seen;
  logic [ADDR_BITS-1:0] slot_address [TABLE_DEPTH];
  logic [6:0]           slot_length  [TABLE_DEPTH];
  logic                 slot_write   [TABLE_DEPTH];
  logic [2:0]           slot_port    [TABLE_DEPTH];
  logic [63:0]          slot_age     [TABLE_DEPTH];

  logic [IW-1:0] j, cand;
  logic [ADDR_BITS-1:0] cand_addr;
  logic [6:0]  cand_len;
  logic [63:0] cand_age, floor_age;
  logic        cand_wr;
  logic [2:0]  cand_port;
  logic        mode_rel, have_floor, found, blk, blocked;

  out_item_t hold;
  logic      hold_valid;
  out_item_t stage_out;

  // single read port
  logic [IW-1:0] rd_idx, tidx;
  logic [ADDR_BITS-1:0] rd_addr, in_addr;
  logic [6:0]  rd_len;
  logic        rd_wr;
  logic [2:0]  rd_port;
  logic [63:0] rd_age;

  assign tidx    = IW'(item.tag);
  assign rd_idx  = (state == S_DECODE) ? tidx : j;
  assign rd_addr = slot_address[rd_idx];
  assign rd_len  = slot_length[rd_idx];
  assign rd_wr   = slot_write[rd_idx];
  assign rd_port = slot_port[rd_idx];
  assign rd_age  = slot_age[rd_idx];
  assign in_addr = ADDR_BITS'(item.address);

  logic tag_ok, known;
  assign tag_ok = 32'(item.tag) < TABLE_DEPTH;
  assign known  = tag_ok && slot_valid[tidx];

  logic full;
  assign full = 32'(pending_count) >= 32'(max_outstanding);

  // x < base + len, sum one bit wider so ranges never wrap
  function automatic logic below_end(input logic [ADDR_BITS-1:0] x,
                                     input logic [ADDR_BITS-1:0] base,
                                     input logic [6:0] len);
    logic [ADDR_BITS:0] s;
    s = {1'b0, base} + (ADDR_BITS+1)'(len);
    return {1'b0, x} < s;
  endfunction

  logic hazard, cand_ok;
  assign hazard = (j != cand) && slot_valid[j] && (rd_age < cand_age) &&
                  !slot_data_done[j] && rd_wr &&
                  below_end(rd_addr, cand_addr, cand_len) &&
                  below_end(cand_addr, rd_addr, rd_len);
  assign cand_ok = slot_valid[j] && slot_committed[j] && !slot_data_done[j] &&
                   (!have_floor || rd_age > floor_age) && (!found || rd_age < cand_age);

  logic [2:0] port_clamp;
  assign port_clamp = (32'(item.port) < NUM_PORTS) ? item.port : 3'(NUM_PORTS - 1);

  // result produced this cycle
  logic      emit_en;
  out_item_t emit_item;
  always_comb begin
    emit_en = 1'b0;
    emit_item = '{event_res: EV_REFUSE, fault: FLT_NONE, out_tag: item.tag,
                  out_port: 3'd0, out_write: 1'b0, last: 1'b0};
    case (state)
      S_DECODE: begin
        case (item.opcode)
          OP_SUBMIT: begin
            emit_en = 1'b1;
            emit_item.out_write = item.write_req;
            if (full) emit_item.fault = FLT_NONE;
            else if (!tag_ok) emit_item.fault = FLT_UNKNOWN;
            else if (slot_valid[tidx]) emit_item.fault = FLT_TAG_USED;
            else emit_item.event_res = EV_ACCEPT;
          end
          OP_COMMIT: begin
            emit_item.out_write = known ? rd_wr : 1'b0;
            if (!known) begin
              emit_en = 1'b1; emit_item.fault = FLT_UNKNOWN;
            end else if (slot_committed[tidx]) begin
              emit_en = 1'b1; emit_item.fault = FLT_TWICE;
            end else if (rd_addr != in_addr) begin
              emit_en = 1'b1; emit_item.fault = FLT_ADDR;
            end
          end
          OP_COMPL: begin
            emit_en = 1'b1;
            emit_item.out_write = known ? rd_wr : 1'b0;
            if (!known) emit_item.fault = FLT_UNKNOWN;
            else if (!slot_committed[tidx]) emit_item.fault = FLT_EARLY_CMPL;
            else if (!slot_data_done[tidx]) emit_item.event_res = EV_PARKED;
            else begin
              emit_item.event_res = EV_RESPOND;
              emit_item.out_port  = rd_port;
            end
          end
          default: emit_en = 1'b0;
        endcase
      end
      S_ACT: begin
        emit_item.out_tag   = 4'(cand);
        emit_item.out_write = cand_wr;
        if (!blocked) begin
          emit_en = 1'b1; emit_item.event_res = EV_PERFORM;
        end else if (!mode_rel) begin
          emit_en = 1'b1; emit_item.event_res = EV_HELD;
        end
      end
      S_RESP: begin
        emit_en = 1'b1;
        emit_item.event_res = EV_RESPOND;
        emit_item.out_tag   = 4'(cand);
        emit_item.out_port  = cand_port;
        emit_item.out_write = cand_wr;
      end
      default: emit_en = 1'b0;
    endcase
  end

  logic out_free, emit_go, flush_go, adv;
  assign out_free = !out_valid || !out_stall;
  assign emit_go  = emit_en && out_free;
  assign flush_go = (state == S_FLUSH) && hold_valid && out_free;
  assign adv      = !emit_en || out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // the staged result is the last one only when it leaves on the flush
  always_comb begin
    stage_out      = hold;
    stage_out.last = flush_go;
  end

  // output staging
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if ((emit_go && hold_valid) || flush_go) begin
        out_data  <= stage_out;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit_go) begin
        hold       <= emit_item;
        hold_valid <= 1'b1;
      end else if (flush_go) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (state == S_DECODE && item.opcode == OP_SUBMIT && !full && tag_ok &&
        !slot_valid[tidx] && out_free) begin
      slot_address[tidx] <= in_addr;
      slot_length[tidx]  <= item.length;
      slot_write[tidx]   <= item.write_req;
      slot_port[tidx]    <= port_clamp;
      slot_age[tidx]     <= next_age;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      max_outstanding <= MAX_OUT_RESET;
      pending_count   <= '0;
      next_age        <= '0;
      slot_valid      <= '0;
    end else begin
      if (cfg_valid) max_outstanding <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (adv) begin
            state <= S_FLUSH;
            case (item.opcode)
              OP_SUBMIT: begin
                if (!full && tag_ok && !slot_valid[tidx]) begin
                  slot_valid[tidx]           <= 1'b1;
                  slot_committed[tidx]       <= 1'b0;
                  slot_data_done[tidx]       <= 1'b0;
                  slot_completion_seen[tidx] <= 1'b0;
                  next_age      <= next_age + 64'd1;
                  pending_count <= pending_count + CW'(1);
                end
              end
              OP_COMMIT: begin
                if (known && !slot_committed[tidx] && rd_addr == in_addr) begin
                  slot_committed[tidx] <= 1'b1;
                  cand      <= tidx;
                  cand_addr <= rd_addr;
                  cand_len  <= rd_len;
                  cand_age  <= rd_age;
                  cand_wr   <= rd_wr;
                  cand_port <= rd_port;
                  mode_rel  <= 1'b0;
                  j         <= '0;
                  blk       <= 1'b0;
                  state     <= S_CHECK;
                end
              end
              OP_COMPL: begin
                if (known && slot_committed[tidx]) begin
                  if (!slot_data_done[tidx]) begin
                    slot_completion_seen[tidx] <= 1'b1;
                  end else begin
                    slot_valid[tidx] <= 1'b0;
                    if (pending_count != '0) pending_count <= pending_count - CW'(1);
                  end
                end
              end
              default: state <= S_FLUSH;
            endcase
          end
        end
        S_CHECK: begin
          blk <= blk | hazard;
          if (j == LAST_IDX) begin
            blocked <= blk | hazard;
            state   <= S_ACT;
          end else begin
            j <= j + IW'(1);
          end
        end
        S_ACT: begin
          if (adv) begin
            if (blocked) begin
              if (!mode_rel) begin
                state <= S_FLUSH;
              end else begin
                floor_age  <= cand_age;
                have_floor <= 1'b1;
                j <= '0; found <= 1'b0;
                state <= S_FIND;
              end
            end else begin
              slot_data_done[cand] <= 1'b1;
              if (slot_completion_seen[cand]) begin
                state <= S_RESP;
              end else if (cand_wr) begin
                mode_rel <= 1'b1; have_floor <= 1'b0;
                j <= '0; found <= 1'b0;
                state <= S_FIND;
              end else if (!mode_rel) begin
                state <= S_FLUSH;
              end else begin
                floor_age <= cand_age; have_floor <= 1'b1;
                j <= '0; found <= 1'b0;
                state <= S_FIND;
              end
            end
          end
        end
        S_RESP: begin
          if (adv) begin
            slot_valid[cand] <= 1'b0;
            if (pending_count != '0) pending_count <= pending_count - CW'(1);
            if (cand_wr) begin
              mode_rel <= 1'b1; have_floor <= 1'b0;
              j <= '0; found <= 1'b0;
              state <= S_FIND;
            end else if (!mode_rel) begin
              state <= S_FLUSH;
            end else begin
              floor_age <= cand_age; have_floor <= 1'b1;
              j <= '0; found <= 1'b0;
              state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          if (cand_ok) begin
            cand      <= j;
            cand_addr <= rd_addr;
            cand_len  <= rd_len;
            cand_age  <= rd_age;
            cand_wr   <= rd_wr;
            cand_port <= rd_port;
            found     <= 1'b1;
          end
          if (j == LAST_IDX) begin
            j   <= '0;
            blk <= 1'b0;
            state <= (found || cand_ok) ? S_CHECK : S_FLUSH;
          end else begin
            j <= j + IW'(1);
          end
        end
        S_FLUSH: begin
          if (!hold_valid || out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/orht_checker.sv]
`timescale 1ns / 1ps
module orht_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input orht_pkg::out_item_t out_data
);
  import orht_pkg::*;

  // a result held by the receiver stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an accepted transaction keeps the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a second transaction at once");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("outputs active after reset");

  a_fault_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fault != FLT_NONE |-> out_data.event_res == EV_REFUSE &&
    out_data.last)
    else $error("fault on a non-refuse result");

endmodule

bind outstanding_request_hazard_table orht_checker u_orht_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
